[sv/amh_pkg.sv]
`timescale 1ns / 1ps
package amh_pkg;

  localparam int KEY_W         = 12;
  localparam int SCORE_W       = 32;
  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_COUNT_DEF = 4096;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SCORE  = 2'd2,
    ACT_MAX    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

endpackage

[sv/amh_ram.sv]
`timescale 1ns / 1ps
module amh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/addressable_max_heap.sv]
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_action, in_key, in_score
// out      output     out_valid / out_stall  out_status, out_result_key,
//                                            out_result_score, out_entry_count
//
// queries read one slot and refused words none; insert climbs from the new leaf until its
// parent is not smaller or it is the root; delete lifts the item to the root, then sifts the
// last entry down from it, comparing with both children where both exist; each step uses the single
// read port of the slot memory (one read, registered, then compare and write back).
// after reset a clearing pass zeroes the whole position table, in_stall high.
// one item is worked at a time; a new word is taken while a result waits on out_stall.
module addressable_max_heap #(
  parameter int CAPACITY  = amh_pkg::CAPACITY_DEF,
  parameter int KEY_COUNT = amh_pkg::KEY_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [amh_pkg::KEY_W-1:0]         in_key,
  input  logic signed [amh_pkg::SCORE_W-1:0] in_score,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [amh_pkg::KEY_W-1:0]         out_result_key,
  output logic signed [amh_pkg::SCORE_W-1:0] out_result_score,
  output logic [$clog2(CAPACITY+1)-1:0]     out_entry_count
);

  import amh_pkg::*;

  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int PAW = $clog2(KEY_COUNT);
  localparam int EW  = $bits(entry_t);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'h0001,
    S_IDLE   = 13'h0002,
    S_LOOK   = 13'h0004,
    S_QRD    = 13'h0008,
    S_UP     = 13'h0010,
    S_UPC    = 13'h0020,
    S_LIFT   = 13'h0040,
    S_LIFTC  = 13'h0080,
    S_LASTRD = 13'h0100,
    S_DN     = 13'h0200,
    S_DNL    = 13'h0400,
    S_DNR    = 13'h0800,
    S_FIN    = 13'h1000
  } state_t;

  state_t state_r, state_nxt;
  act_t act_r, act_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  entry_t m_r, m_nxt;
  entry_t l_r, l_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [SW-1:0] hole_r, hole_nxt;
  logic [PAW-1:0] clr_r, clr_nxt;
  status_t res_status_r, res_status_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  logic signed [SCORE_W-1:0] res_score_r, res_score_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [SW-1:0] out_count_r, out_count_nxt;

  logic slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  entry_t slot_wdata;
  logic [EW-1:0] slot_rdata;
  entry_t sq;
  logic pos_we;
  logic [PAW-1:0] pos_waddr;
  logic [SW-1:0] pos_wdata, pos_q;

  logic accept, key_ok, out_free;
  logic [SW-1:0] pos_eff, parent;
  logic [SW:0] left, right;
  logic signed [SCORE_W-1:0] big_score;
  logic pick_l, pick_r;

  amh_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  amh_ram #(.WIDTH(SW), .DEPTH(KEY_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (PAW'(in_key)),
    .rdata (pos_q)
  );

  assign sq       = entry_t'(slot_rdata);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign key_ok   = 32'(key_r) < 32'(KEY_COUNT);
  assign pos_eff  = (key_ok && (pos_q <= size_r)) ? pos_q : '0;
  assign parent   = hole_r >> 1;
  assign left     = {hole_r, 1'b0};
  assign right    = left + 1'b1;
  assign pick_l    = !(l_r.score < m_r.score);
  assign big_score = pick_l ? l_r.score : m_r.score;
  assign pick_r    = !(sq.score < big_score);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    m_nxt          = m_r;
    l_nxt          = l_r;
    size_nxt       = size_r;
    hole_nxt       = hole_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_score_nxt  = res_score_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_score_nxt  = out_score_r;
    out_count_nxt  = out_count_r;
    slot_we        = 1'b0;
    slot_waddr     = hole_r;
    slot_wdata     = m_r;
    slot_raddr     = parent;
    pos_we         = 1'b0;
    pos_waddr      = PAW'(m_r.key);
    pos_wdata      = hole_r;

    case (state_r)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == PAW'(KEY_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt        = act_t'(in_action);
          key_nxt        = in_key;
          m_nxt.key      = in_key;
          m_nxt.score    = in_score;
          res_status_nxt = ST_OK;
          res_key_nxt    = in_key;
          res_score_nxt  = '0;
          state_nxt      = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_FIN;
        case (act_r)
          ACT_INSERT: begin
            if (!key_ok) begin
              res_status_nxt = ST_ABSENT;
            end else if (pos_eff != '0) begin
              res_status_nxt = ST_DUP;
            end else if (size_r == SW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              size_nxt      = size_r + 1'b1;
              hole_nxt      = size_r + 1'b1;
              res_score_nxt = m_r.score;
              state_nxt     = S_UP;
            end
          end
          ACT_DELETE: begin
            if (pos_eff == '0) begin
              res_status_nxt = ST_ABSENT;
            end else begin
              hole_nxt  = pos_eff;
              state_nxt = S_LIFT;
            end
          end
          ACT_SCORE: begin
            if (pos_eff == '0) begin
              res_status_nxt = ST_ABSENT;
            end else begin
              slot_raddr = pos_eff;
              state_nxt  = S_QRD;
            end
          end
          default: begin
            if (size_r == '0) begin
              res_status_nxt = ST_ABSENT;
              res_key_nxt    = '0;
            end else begin
              slot_raddr = SW'(1);
              state_nxt  = S_QRD;
            end
          end
        endcase
      end
      S_QRD: begin
        res_score_nxt = sq.score;
        if (act_r == ACT_MAX) begin
          res_key_nxt = sq.key;
        end
        state_nxt = S_FIN;
      end
      S_UP: begin
        if (hole_r == SW'(1)) begin
          slot_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (sq.score < m_r.score) begin
          // parent moves down into the hole
          slot_wdata = sq;
          pos_waddr  = PAW'(sq.key);
          hole_nxt   = parent;
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LIFT: begin
        if (hole_r == SW'(1)) begin
          pos_we    = 1'b1;
          pos_waddr = PAW'(key_r);
          pos_wdata = '0;
          if (size_r == SW'(1)) begin
            size_nxt  = '0;
            state_nxt = S_FIN;
          end else begin
            slot_raddr = size_r;
            state_nxt  = S_LASTRD;
          end
        end else begin
          state_nxt = S_LIFTC;
        end
      end
      S_LIFTC: begin
        slot_we    = 1'b1;
        slot_wdata = sq;
        pos_we     = 1'b1;
        pos_waddr  = PAW'(sq.key);
        hole_nxt   = parent;
        state_nxt  = S_LIFT;
      end
      S_LASTRD: begin
        m_nxt     = sq;
        size_nxt  = size_r - 1'b1;
        hole_nxt  = SW'(1);
        state_nxt = S_DN;
      end
      S_DN: begin
        if (left > {1'b0, size_r}) begin
          slot_we   = 1'b1;
          pos_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          slot_raddr = SW'(left);
          state_nxt  = S_DNL;
        end
      end
      S_DNL: begin
        l_nxt = sq;
        if (right <= {1'b0, size_r}) begin
          slot_raddr = SW'(right);
          state_nxt  = S_DNR;
        end else begin
          slot_we = 1'b1;
          pos_we  = 1'b1;
          if (!(sq.score < m_r.score)) begin
            slot_wdata = sq;
            pos_waddr  = PAW'(sq.key);
            hole_nxt   = SW'(left);
            state_nxt  = S_DN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DNR: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        // ties go to the child, right before left
        if (pick_r) begin
          slot_wdata = sq;
          pos_waddr  = PAW'(sq.key);
          hole_nxt   = SW'(right);
          state_nxt  = S_DN;
        end else if (pick_l) begin
          slot_wdata = l_r;
          pos_waddr  = PAW'(l_r.key);
          hole_nxt   = SW'(left);
          state_nxt  = S_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_score_nxt  = res_score_r;
          out_count_nxt  = size_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    m_r          <= m_nxt;
    l_r          <= l_nxt;
    hole_r       <= hole_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_score_r  <= res_score_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_score_r  <= out_score_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_key   = out_key_r;
  assign out_result_score = out_score_r;
  assign out_entry_count  = out_count_r;

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SW'(CAPACITY))
    else $error("heap size beyond capacity");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word loaded outside finish");

  a_hole_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP || state_r == S_UPC || state_r == S_LIFT || state_r == S_LIFTC ||
     state_r == S_DN || state_r == S_DNL || state_r == S_DNR) |-> hole_r != '0)
    else $error("hole slot is zero while sifting");

  a_no_mem_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !slot_we && !pos_we)
    else $error("memory write while no item in work");
`endif

endmodule

[bench/tb_addressable_max_heap.sv]
`timescale 1ns / 1ps
module tb_addressable_max_heap;
  import amh_pkg::*;

  localparam int CAP      = 1024;
  localparam int NKEYS    = 4096;
  localparam int N_RANDOM = 340;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [KEY_W-1:0] out_result_key;
  logic signed [SCORE_W-1:0] out_result_score;
  logic [10:0] out_entry_count;

  addressable_max_heap u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_key(in_key), .in_score(in_score),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_key(out_result_key),
    .out_result_score(out_result_score), .out_entry_count(out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    status_t status;
    logic [KEY_W-1:0] rkey;
    logic signed [SCORE_W-1:0] rscore;
    logic [10:0] count;
  } heap_reply_t;

  typedef struct {
    act_t act;
    logic [KEY_W-1:0] key;
    logic signed [SCORE_W-1:0] score;
    bit fixed;
    heap_reply_t reply;
  } op_row_t;

  // shadow heap
  logic [KEY_W-1:0] sh_key[CAP+1];
  logic signed [SCORE_W-1:0] sh_score[CAP+1];
  int unsigned sh_pos[NKEYS];
  int unsigned sh_size;

  heap_reply_t pending_replies[$];
  int errors = 0;
  int mismatches = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic void swap_slots(int unsigned i, int unsigned j);
    logic [KEY_W-1:0] k;
    logic signed [SCORE_W-1:0] s;
    k = sh_key[i]; s = sh_score[i];
    sh_key[i] = sh_key[j]; sh_score[i] = sh_score[j];
    sh_key[j] = k; sh_score[j] = s;
    sh_pos[sh_key[i]] = i;
    sh_pos[sh_key[j]] = j;
  endfunction

  function automatic heap_reply_t apply_action(act_t act, logic [KEY_W-1:0] key,
                                               logic signed [SCORE_W-1:0] score);
    heap_reply_t r;
    int unsigned pos, i, l, big;
    r.status = ST_OK; r.rkey = key; r.rscore = '0;
    pos = sh_pos[key];
    if (pos > sh_size) pos = 0;
    case (act)
      ACT_INSERT: begin
        if (pos != 0) r.status = ST_DUP;
        else if (sh_size >= CAP) r.status = ST_FULL;
        else begin
          sh_size++;
          i = sh_size;
          sh_key[i] = key; sh_score[i] = score; sh_pos[key] = i;
          while (i > 1 && sh_score[i >> 1] < sh_score[i]) begin
            swap_slots(i, i >> 1);
            i >>= 1;
          end
          r.rscore = score;
        end
      end
      ACT_DELETE: begin
        if (pos == 0) r.status = ST_ABSENT;
        else begin
          for (i = pos; i > 1; i >>= 1) swap_slots(i, i >> 1);
          swap_slots(1, sh_size);
          sh_pos[key] = 0;
          sh_size--;
          i = 1;
          forever begin
            l = 2 * i;
            big = i;
            // ties go to the child, right over left
            if (l <= sh_size && !(sh_score[l] < sh_score[i])) big = l;
            if (l + 1 <= sh_size && !(sh_score[l+1] < sh_score[big])) big = l + 1;
            if (big == i) break;
            swap_slots(i, big);
            i = big;
          end
        end
      end
      ACT_SCORE: begin
        if (pos == 0) r.status = ST_ABSENT;
        else r.rscore = sh_score[pos];
      end
      default: begin
        if (sh_size == 0) begin
          r.status = ST_ABSENT; r.rkey = '0;
        end else begin
          r.rkey = sh_key[1]; r.rscore = sh_score[1];
        end
      end
    endcase
    r.count = sh_size[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_addressable_max_heap: errors");
      $finish;
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else begin
        mode = int'((cycles / 3000) % 3);
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    heap_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result word: st=%0d key=%0d score=%0d n=%0d",
                   out_status, out_result_key, out_result_score, out_entry_count);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status || out_result_key !== want.rkey ||
            out_result_score !== want.rscore || out_entry_count !== want.count) begin
          errors++;
          if (mismatches < 10)
            $display({"mismatch: exp st=%0d key=%0d score=%0d n=%0d, ",
                      "got st=%0d key=%0d score=%0d n=%0d"},
                     want.status, want.rkey, want.rscore, want.count,
                     out_status, out_result_key, out_result_score, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(act_t act, logic [KEY_W-1:0] key,
                           logic signed [SCORE_W-1:0] score,
                           bit fixed, heap_reply_t reply);
    heap_reply_t r;
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= key;
    in_score <= score;
    do @(posedge clk); while (in_stall);
    r = apply_action(act, key, score);
    if (fixed && r !== reply) begin
      errors++;
      $display("table row disagrees with prediction: act=%0d key=%0d", act, key);
    end
    pending_replies.push_back(r);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic heap_reply_t mk(status_t st, logic [KEY_W-1:0] k,
                                     logic signed [SCORE_W-1:0] s, logic [10:0] n);
    heap_reply_t r;
    r.status = st; r.rkey = k; r.rscore = s; r.count = n;
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 7)) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    op_row_t rows[$];
    int burst;
    int k, sel;
    act_t a;
    heap_reply_t none;
    none = '0;
    sh_size = 0;
    foreach (sh_pos[i]) sh_pos[i] = 0;

    rows.push_back('{ACT_MAX, 12'd5, 32'sd0, 1, mk(ST_ABSENT, 12'd0, 32'sd0, 11'd0)});
    rows.push_back('{ACT_DELETE, 12'd7, 32'sd0, 1, mk(ST_ABSENT, 12'd7, 32'sd0, 11'd0)});
    rows.push_back('{ACT_SCORE, 12'd4095, 32'sd0, 1, mk(ST_ABSENT, 12'd4095, 32'sd0, 11'd0)});
    rows.push_back('{ACT_INSERT, 12'd0, 32'sh80000000, 1,
                     mk(ST_OK, 12'd0, 32'sh80000000, 11'd1)});
    rows.push_back('{ACT_INSERT, 12'd4095, 32'sh7fffffff, 1,
                     mk(ST_OK, 12'd4095, 32'sh7fffffff, 11'd2)});
    rows.push_back('{ACT_INSERT, 12'd4095, 32'sd1, 1, mk(ST_DUP, 12'd4095, 32'sd0, 11'd2)});
    rows.push_back('{ACT_MAX, 12'd0, 32'sd0, 1, mk(ST_OK, 12'd4095, 32'sh7fffffff, 11'd2)});
    rows.push_back('{ACT_INSERT, 12'd100, 32'sh7fffffff, 0, none});
    rows.push_back('{ACT_INSERT, 12'd101, 32'sd0, 0, none});
    rows.push_back('{ACT_INSERT, 12'd102, 32'sd0, 0, none});
    rows.push_back('{ACT_INSERT, 12'd103, -32'sd1, 0, none});
    rows.push_back('{ACT_MAX, 12'd0, 32'sd0, 0, none});
    rows.push_back('{ACT_SCORE, 12'd0, 32'sd0, 0, none});
    rows.push_back('{ACT_DELETE, 12'd4095, 32'sd0, 0, none});
    rows.push_back('{ACT_MAX, 12'd0, 32'sd0, 0, none});
    rows.push_back('{ACT_DELETE, 12'd102, 32'sd0, 0, none});
    rows.push_back('{ACT_DELETE, 12'd0, 32'sd0, 0, none});
    rows.push_back('{ACT_SCORE, 12'd0, 32'sd0, 0, none});
    rows.push_back('{ACT_MAX, 12'd0, 32'sd0, 0, none});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_word(rows[i].act, rows[i].key, rows[i].score, rows[i].fixed, rows[i].reply);
      idle_gap();
    end

    // fill to capacity, with the receiver holding off at the start, then probe the full and duplicate cases
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    k = 0;
    while (sh_size < CAP) begin
      if (sh_pos[k] == 0)
        send_word(ACT_INSERT, k[KEY_W-1:0], rand_score(), 0, none);
      k++;
    end
    send_word(ACT_INSERT, 12'd4000, 32'sd5, 1, mk(ST_FULL, 12'd4000, 32'sd0, 11'd1024));
    send_word(ACT_INSERT, 12'd3, 32'sd5, 1, mk(ST_DUP, 12'd3, 32'sd0, 11'd1024));
    // drain half the heap by deleting random present keys
    while (sh_size > CAP / 2) begin
      send_word(ACT_DELETE, sh_key[$urandom_range(1, sh_size)], $signed($urandom()), 0, none);
      idle_gap();
    end

    // random part: small key pool so hits, dups and deletes are common
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) a = ACT_INSERT;
      else if (sel < 7) a = ACT_DELETE;
      else if (sel < 9) a = ACT_SCORE;
      else a = ACT_MAX;
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, NKEYS - 1);
      else k = $urandom_range(0, 63) * 64 + $urandom_range(0, 1) * 63;
      send_word(a, k[KEY_W-1:0], rand_score(), 0, none);
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end else burst--;
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("tb_addressable_max_heap: clean");
    else
      $display("tb_addressable_max_heap: errors");
    $finish;
  end

endmodule

[sim.f]
sv/amh_pkg.sv
sv/amh_ram.sv
sv/addressable_max_heap.sv
bench/tb_addressable_max_heap.sv
